// ----- rtl/core/iso14443a_card_select_sequencer_unit_macros.svh -----
// Assertion macros shared by the card select sequencer RTL.
`ifndef ISO14443A_CARD_SELECT_SEQUENCER_UNIT_MACROS_SVH
`define ISO14443A_CARD_SELECT_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define ISOCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property only when a condition holds.
`define ISOCS_ASSERT_IF(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`else

`define ISOCS_ASSERT(lbl, prop, msg)
`define ISOCS_ASSERT_IF(lbl, cond, prop, msg)

`endif

`endif

// ----- rtl/core/isocs_pkg.sv -----
// Types and constants of the ISO14443A card select sequencer.
`default_nettype none

package isocs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_REQ  = 3'd1,
    PH_WUP  = 3'd2,
    PH_AC   = 3'd3,
    PH_SEL  = 3'd4
  } phase_e;

  // Frame kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_REQA  = 3'd1;
  localparam logic [2:0] KIND_WUPA  = 3'd2;
  localparam logic [2:0] KIND_ANTIC = 3'd3;
  localparam logic [2:0] KIND_SEL   = 3'd4;

  // Completion status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_CARD   = 2'd1;
  localparam logic [1:0] ST_COLLISION = 2'd2;
  localparam logic [1:0] ST_PROTOCOL  = 2'd3;

  localparam logic [7:0] CASCADE_TAG = 8'h88;
  localparam int unsigned SAK_CASCADE_BIT = 2;
  localparam logic [7:0] SEL_BASE = 8'h93;

  // Input commands
  localparam logic FUNC_START = 1'b0;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  level;
    logic [2:0]  attempts;
    logic [39:0] level_uid;
    logic [3:0]  uid_count;
    logic [15:0] atqa;
    logic [7:0]  sak;
  } state_t;

  typedef struct packed {
    logic [2:0]  tx_kind;
    logic [7:0]  tx_sel;
    logic [39:0] tx_uid;
    logic        delay_first;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] atqa_value;
    logic [7:0]  sak_value;
    logic [31:0] uid_chunk;
    logic [2:0]  chunk_len;
    logic [3:0]  uid_total;
  } result_t;

  // SEL code of a cascade level: 0x93, 0x95, 0x97
  function automatic logic [7:0] sel_code(input logic [1:0] lv);
    sel_code = SEL_BASE + {5'd0, lv, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/isocs_step.sv -----
// Next-state and result logic for one sequencer transaction.
`default_nettype none

module isocs_step import isocs_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 3
) (
  input  state_t      cur_i,
  input  logic        func_i,
  input  logic [2:0]  resp_len_i,
  input  logic [39:0] resp_data_i,
  input  logic [2:0]  tries_i,
  output state_t      nxt_o,
  output result_t     res_o
);

  localparam logic [1:0] LastLevel = 2'(MAX_LEVELS - 1);

  logic [2:0]  tries;
  logic [2:0]  att_inc;
  logic        is_tag;
  logic [31:0] chunk;
  logic [2:0]  clen;

  assign tries   = (tries_i == 3'd0) ? 3'd1 : tries_i;
  assign att_inc = cur_i.attempts + 3'd1;
  assign is_tag  = (cur_i.level_uid[7:0] == CASCADE_TAG);
  assign chunk   = is_tag ? {8'd0, cur_i.level_uid[31:8]} : cur_i.level_uid[31:0];
  assign clen    = is_tag ? 3'd3 : 3'd4;

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    res_o.tx_kind = KIND_NONE;
    if (func_i == FUNC_START) begin
      nxt_o = '0;
      nxt_o.phase = PH_REQ;
      res_o.tx_kind = KIND_REQA;
    end else begin
      case (cur_i.phase)
        PH_REQ, PH_WUP: begin
          if (resp_len_i >= 3'd2) begin
            nxt_o.atqa     = resp_data_i[15:0];
            nxt_o.level    = 2'd0;
            nxt_o.attempts = 3'd0;
            nxt_o.phase    = PH_AC;
            res_o.tx_kind  = KIND_ANTIC;
            res_o.tx_sel   = sel_code(2'd0);
          end else if (cur_i.phase == PH_REQ) begin
            nxt_o.phase       = PH_WUP;
            res_o.tx_kind     = KIND_WUPA;
            res_o.delay_first = 1'b1;
          end else begin
            nxt_o.phase    = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = ST_NO_CARD;
          end
        end
        PH_AC: begin
          if (resp_len_i == 3'd5) begin
            nxt_o.level_uid = resp_data_i;
            nxt_o.phase     = PH_SEL;
            res_o.tx_kind   = KIND_SEL;
            res_o.tx_sel    = sel_code(cur_i.level);
            res_o.tx_uid    = resp_data_i;
          end else begin
            nxt_o.attempts = att_inc;
            if (att_inc >= tries) begin
              nxt_o.phase    = PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.status   = ST_COLLISION;
            end else begin
              res_o.tx_kind     = KIND_ANTIC;
              res_o.tx_sel      = sel_code(cur_i.level);
              res_o.delay_first = 1'b1;
            end
          end
        end
        PH_SEL: begin
          if (resp_len_i >= 3'd1) begin
            nxt_o.sak       = resp_data_i[7:0];
            nxt_o.uid_count = cur_i.uid_count + {1'b0, clen};
            res_o.uid_chunk = chunk;
            res_o.chunk_len = clen;
            if (resp_data_i[SAK_CASCADE_BIT] && (cur_i.level < LastLevel)) begin
              nxt_o.level    = cur_i.level + 2'd1;
              nxt_o.attempts = 3'd0;
              nxt_o.phase    = PH_AC;
              res_o.tx_kind  = KIND_ANTIC;
              res_o.tx_sel   = sel_code(cur_i.level + 2'd1);
            end else begin
              nxt_o.phase    = PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.status   = ST_OK;
            end
          end else begin
            nxt_o.phase    = PH_IDLE;
            res_o.done_res = 1'b1;
            res_o.status   = ST_PROTOCOL;
          end
        end
        default: begin
          // Idle: drop the response, show held values
        end
      endcase
    end
    res_o.atqa_value = nxt_o.atqa;
    res_o.sak_value  = nxt_o.sak;
    res_o.uid_total  = nxt_o.uid_count;
  end

endmodule

`default_nettype wire

// ----- rtl/core/iso14443a_card_select_sequencer_unit.sv -----
// Top level of the ISO14443A card select sequencer.
`default_nettype none

`include "iso14443a_card_select_sequencer_unit_macros.svh"

// Reader-side sequencer for ISO14443A card selection. Send a start transaction
// (tuser 0) to begin: the block answers with REQA. Feed every radio answer or
// timeout back as a response transaction (tuser 1, length 0 for a timeout) and
// each one yields exactly one result transaction naming the next frame to
// transmit (REQA, WUPA, anticollision or SELECT with its SEL code and five
// UID/BCC bytes), whether to wait 5 ms first, and on completion the status
// together with ATQA, SAK and the UID bytes gathered at this level. A start
// transaction while busy restarts the sequence and clears the held data; a
// response while idle gives an empty result that shows the held values.
// Throughput is one transaction per clock while the result stream is not stalled;
// each transaction passes through the input register and the result register
// around the combinational step logic that reads and updates the sequencer state.
// Write anticoll_tries only while the block is idle; 0 behaves as 1.
module iso14443a_card_select_sequencer_unit import isocs_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: anticoll_tries
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_wdata_i,
  // Response / start stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // resp_len[2:0], resp_data[42:3], zero[47:43]
  input  logic         s_axis_tuser,  // func[0]
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tx_sel[7:0], tx_uid[47:8], delay_first[48], done_res[49], status[51:50],
  // atqa_value[67:52], sak_value[75:68], uid_chunk[107:76], chunk_len[110:108],
  // uid_total[114:111], zero[119:115]
  output logic [119:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser   // tx_kind[2:0]
);

  logic [2:0]  tries_q;

  // Input register
  logic        in_vld_q;
  logic        func_q;
  logic [2:0]  len_q;
  logic [39:0] data_q;

  // Sequencer state
  state_t      state_q, state_d;

  // Result register
  logic        out_vld_q;
  result_t     res_q, res_d;

  logic        in_acc;
  logic        advance;

  // Step one item whenever the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  isocs_step #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_step (
    .cur_i       (state_q),
    .func_i      (func_q),
    .resp_len_i  (len_q),
    .resp_data_i (data_q),
    .tries_i     (tries_q),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tries_q <= 3'd3;
    end else if (cfg_we_i) begin
      tries_q <= cfg_wdata_i;
    end
  end

  // Control: input and result valid flags, sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: hold until the next transaction replaces it
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tuser;
      len_q  <= s_axis_tdata[2:0];
      data_q <= s_axis_tdata[42:3];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.tx_kind;
  assign m_axis_tdata  = {5'd0, res_q.uid_total, res_q.chunk_len, res_q.uid_chunk,
                          res_q.sak_value, res_q.atqa_value, res_q.status,
                          res_q.done_res, res_q.delay_first, res_q.tx_uid,
                          res_q.tx_sel};

  // A stepped item always lands in the result register
  `ISOCS_ASSERT(a_step_lands, advance |=> out_vld_q, "stepped item not presented")
  // A held input item is never dropped without stepping
  `ISOCS_ASSERT(a_in_kept, (in_vld_q && !advance) |=> in_vld_q, "input item lost")
  // Completion always returns the sequencer to idle
  `ISOCS_ASSERT(a_done_idle, (advance && res_d.done_res) |=> (state_q.phase == PH_IDLE),
                "done without returning to idle")
  // Status is only meaningful on completion
  `ISOCS_ASSERT_IF(a_status_done, out_vld_q && !res_q.done_res, res_q.status == ST_OK,
                   "status set without done")
  // A UID chunk is three or four bytes, or none
  `ISOCS_ASSERT_IF(a_chunk_len, out_vld_q,
                   (res_q.chunk_len == 3'd0) || (res_q.chunk_len == 3'd3) ||
                   (res_q.chunk_len == 3'd4), "bad chunk length")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the ISO14443A card select sequencer unit.
`timescale 1ns / 1ps

module tb_top;
  import isocs_pkg::*;

  localparam int SEL_LEVELS     = 3;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int MAX_PRINTED    = 30;
  localparam int RANDOM_PHASE   = 370;

  // Input tuser values
  localparam logic FUNC_RESP = 1'b1;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stimulus side, all known from time zero
  logic         cfg_we_i      = 1'b0;
  logic [2:0]   cfg_wdata_i   = 3'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata  = 48'd0;  // resp_len[2:0], resp_data[42:3], zero[47:43]
  logic         s_axis_tuser  = 1'b0;   // func[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tx_sel[7:0], tx_uid[47:8], delay_first[48], done_res[49], status[51:50],
  // atqa_value[67:52], sak_value[75:68], uid_chunk[107:76], chunk_len[110:108],
  // uid_total[114:111], zero[119:115]
  logic [119:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;           // tx_kind[2:0]

  iso14443a_card_select_sequencer_unit #(
    .MAX_LEVELS(SEL_LEVELS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Sequencer state as the testbench expects it to be
  phase_e      seq_phase    = PH_IDLE;
  logic [1:0]  seq_level    = 2'd0;
  logic [2:0]  seq_attempts = 3'd0;
  logic [39:0] seq_uid      = 40'd0;
  logic [3:0]  seq_count    = 4'd0;
  logic [15:0] seq_atqa     = 16'd0;
  logic [7:0]  seq_sak      = 8'd0;
  logic [2:0]  tries_reg    = 3'd3;

  // Frames still owed by the block, oldest first
  result_t due_frames[$];

  int  cycle_count  = 0;
  int  error_count  = 0;
  int  total_items  = 0;
  int  live_items   = 0;
  int  frames_seen  = 0;
  int  finish_hits[4];
  bit  steady       = 1'b0;   // both sides run without gaps while set
  bit  rx_hold_req  = 1'b0;   // ask the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Predictor: advance the expected state by one accepted transaction and
  // return the result frame it must produce.
  // ---------------------------------------------------------------------------
  function automatic result_t step_sequencer(input logic func, input logic [2:0] len,
                                             input logic [39:0] data);
    result_t    r;
    logic [2:0] tries;
    r     = '0;
    tries = (tries_reg == 3'd0) ? 3'd1 : tries_reg;
    if (func == FUNC_START) begin
      // Start always restarts from REQA and drops everything held
      seq_level    = 2'd0;
      seq_attempts = 3'd0;
      seq_uid      = 40'd0;
      seq_count    = 4'd0;
      seq_atqa     = 16'd0;
      seq_sak      = 8'd0;
      seq_phase    = PH_REQ;
      r.tx_kind    = KIND_REQA;
    end else begin
      case (seq_phase)
        PH_REQ, PH_WUP: begin
          if (len >= 3'd2) begin
            seq_atqa     = data[15:0];
            seq_level    = 2'd0;
            seq_attempts = 3'd0;
            seq_phase    = PH_AC;
            r.tx_kind    = KIND_ANTIC;
            r.tx_sel     = SEL_BASE;
          end else if (seq_phase == PH_REQ) begin
            // No answer to REQA: try WUPA after the guard wait
            seq_phase     = PH_WUP;
            r.tx_kind     = KIND_WUPA;
            r.delay_first = 1'b1;
          end else begin
            seq_phase  = PH_IDLE;
            r.done_res = 1'b1;
            r.status   = ST_NO_CARD;
          end
        end
        PH_AC: begin
          if (len == 3'd5) begin
            seq_uid   = data;
            seq_phase = PH_SEL;
            r.tx_kind = KIND_SEL;
            r.tx_sel  = SEL_BASE + {5'd0, seq_level, 1'b0};
            r.tx_uid  = data;
          end else begin
            seq_attempts = seq_attempts + 3'd1;
            if (seq_attempts >= tries) begin
              seq_phase  = PH_IDLE;
              r.done_res = 1'b1;
              r.status   = ST_COLLISION;
            end else begin
              r.tx_kind     = KIND_ANTIC;
              r.tx_sel      = SEL_BASE + {5'd0, seq_level, 1'b0};
              r.delay_first = 1'b1;
            end
          end
        end
        PH_SEL: begin
          if (len != 3'd0) begin
            seq_sak = data[7:0];
            // A cascade tag in byte 0 means only bytes 1..3 belong to the UID
            if (seq_uid[7:0] == CASCADE_TAG) begin
              r.uid_chunk = {8'd0, seq_uid[31:8]};
              r.chunk_len = 3'd3;
            end else begin
              r.uid_chunk = seq_uid[31:0];
              r.chunk_len = 3'd4;
            end
            seq_count = seq_count + {1'b0, r.chunk_len};
            if (seq_sak[SAK_CASCADE_BIT] && (seq_level + 1 < SEL_LEVELS)) begin
              seq_level    = seq_level + 2'd1;
              seq_attempts = 3'd0;
              seq_phase    = PH_AC;
              r.tx_kind    = KIND_ANTIC;
              r.tx_sel     = SEL_BASE + {5'd0, seq_level, 1'b0};
            end else begin
              seq_phase  = PH_IDLE;
              r.done_res = 1'b1;
              r.status   = ST_OK;
            end
          end else begin
            seq_phase  = PH_IDLE;
            r.done_res = 1'b1;
            r.status   = ST_PROTOCOL;
          end
        end
        default: ;  // idle: a response only shows the held values
      endcase
    end
    r.atqa_value = seq_atqa;
    r.sak_value  = seq_sak;
    r.uid_total  = seq_count;
    if (r.done_res) finish_hits[r.status]++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [39:0] rand_bytes();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[39:0];
  endfunction

  // Any length that makes anticollision fail: 0..4, 6, 7
  function automatic logic [2:0] fail_len();
    int v;
    v = $urandom_range(0, 5);
    if (v == 5) v = $urandom_range(6, 7);
    return v[2:0];
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Offer one transaction after a random gap and log its expected frame once
  // the block takes it.
  task automatic send_item(input logic func, input logic [2:0] len, input logic [39:0] data);
    int   gap;
    logic ignored;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i) s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'd0, data, len};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    ignored = (func != FUNC_START) && (seq_phase == PH_IDLE);
    due_frames.push_back(step_sequencer(func, len, data));
    total_items++;
    if (!ignored) live_items++;
  endtask

  // Drop valid, wait for every owed frame, then let the pipeline settle.
  // Call straight after the last send_item of a phase.
  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tries(input logic [2:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    tries_reg = value;
  endtask

  // Mostly well-formed selection runs with random content, some noise
  task automatic random_items(input int count);
    int          goal;
    int          roll;
    logic [39:0] data;
    goal = live_items + count;
    while (live_items < goal) begin
      roll = $urandom_range(0, 99);
      data = rand_bytes();
      if (roll < 8) begin
        send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), data);
      end else if (seq_phase == PH_IDLE || roll < 11) begin
        send_item(FUNC_START, 3'($urandom_range(0, 7)), data);
      end else begin
        case (seq_phase)
          PH_REQ, PH_WUP:
            if (roll < 75) send_item(FUNC_RESP, 3'($urandom_range(2, 7)), data);
            else send_item(FUNC_RESP, 3'($urandom_range(0, 1)), data);
          PH_AC: begin
            if ($urandom_range(0, 1)) data[7:0] = CASCADE_TAG;
            if (roll < 78) send_item(FUNC_RESP, 3'd5, data);
            else send_item(FUNC_RESP, fail_len(), data);
          end
          default: begin
            data[SAK_CASCADE_BIT] = ($urandom_range(0, 9) < 6);
            if (roll < 90) send_item(FUNC_RESP, 3'($urandom_range(1, 7)), data);
            else send_item(FUNC_RESP, 3'd0, data);
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // Response with nothing going on
    send_item(FUNC_RESP, 3'd5, 40'hFF_FFFF_FFFF);
    // No card: REQA and WUPA both unanswered
    send_item(FUNC_START, 3'd0, 40'd0);
    send_item(FUNC_RESP, 3'd0, rand_bytes());
    send_item(FUNC_RESP, 3'd1, rand_bytes());
    // Collision after the default three tries; over-long lengths on the way
    send_item(FUNC_START, 3'd7, 40'hFF_FFFF_FFFF);
    send_item(FUNC_RESP, 3'd7, 40'hFF_FFFF_FFFF);
    send_item(FUNC_RESP, 3'd4, rand_bytes());
    send_item(FUNC_RESP, 3'd6, rand_bytes());
    send_item(FUNC_RESP, 3'd0, 40'd0);
    // Triple-size UID, cascade tag at every level, extra level asked at the last
    send_item(FUNC_START, 3'd0, 40'd0);
    send_item(FUNC_RESP, 3'd2, 40'h00_0000_0344);
    send_item(FUNC_RESP, 3'd5, 40'hBC_3322_1188);
    send_item(FUNC_RESP, 3'd1, 40'h00_0000_0024);
    send_item(FUNC_RESP, 3'd5, 40'h5A_6655_4488);
    send_item(FUNC_RESP, 3'd7, 40'hFF_FFFF_FF04);
    send_item(FUNC_RESP, 3'd5, 40'h0F_0A09_0888);
    send_item(FUNC_RESP, 3'd1, 40'h00_0000_0004);
    // Select unanswered: protocol error
    send_item(FUNC_START, 3'd0, 40'd0);
    send_item(FUNC_RESP, 3'd3, 40'h00_0000_0004);
    send_item(FUNC_RESP, 3'd5, 40'd0);
    send_item(FUNC_RESP, 3'd0, 40'hFF_FFFF_FFFF);
    // Restart while busy, then a single-size UID through WUPA
    send_item(FUNC_START, 3'd0, 40'd0);
    send_item(FUNC_RESP, 3'd2, 40'h00_0000_ABCD);
    send_item(FUNC_START, 3'd0, 40'd0);
    send_item(FUNC_RESP, 3'd0, 40'd0);
    send_item(FUNC_RESP, 3'd2, 40'h00_0000_0004);
    send_item(FUNC_RESP, 3'd5, 40'hFF_FFFF_FFFF);
    send_item(FUNC_RESP, 3'd1, 40'h00_0000_0000);
    drain();
  endtask

  task automatic test_retry_limits();
    logic [2:0] settings[3];
    int         eff;
    settings = '{3'd0, 3'd7, 3'd1};
    foreach (settings[i]) begin
      write_tries(settings[i]);
      eff = (settings[i] == 3'd0) ? 1 : int'(settings[i]);
      // Exhaust the retries, then one run that succeeds on the last try
      send_item(FUNC_START, 3'd0, 40'd0);
      send_item(FUNC_RESP, 3'd2, rand_bytes());
      repeat (eff) send_item(FUNC_RESP, fail_len(), rand_bytes());
      send_item(FUNC_START, 3'd0, 40'd0);
      send_item(FUNC_RESP, 3'd2, rand_bytes());
      repeat (eff - 1) send_item(FUNC_RESP, fail_len(), rand_bytes());
      send_item(FUNC_RESP, 3'd5, rand_bytes());
      send_item(FUNC_RESP, 3'd1, rand_bytes());
      drain();
    end
  endtask

  task automatic test_random_traffic();
    logic [2:0] settings[5];
    settings = '{3'd3, 3'd7, 3'd0, 3'd1, 3'($urandom_range(2, 6))};
    foreach (settings[i]) begin
      write_tries(settings[i]);
      steady = (i == 2);  // one phase back to back on both sides
      random_items(RANDOM_PHASE);
      drain();
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    // Hold the receiver off while the sender streams, so the input stalls
    steady      = 1'b1;
    rx_hold_req = 1'b1;
    random_items(80);
    drain();
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per frame, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i) m_axis_tready <= 1'b0;
      end
      stall = pick_gap();
      repeat (stall) @(negedge clk_i) m_axis_tready <= 1'b0;
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every result transaction with the oldest owed frame
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      frames_seen++;
      if (due_frames.size() == 0) begin
        report_mismatch("result with nothing owed");
      end else begin
        want = due_frames.pop_front();
        check_field("tx_kind", 64'(m_axis_tuser), 64'(want.tx_kind));
        check_field("tx_sel", 64'(m_axis_tdata[7:0]), 64'(want.tx_sel));
        check_field("tx_uid", 64'(m_axis_tdata[47:8]), 64'(want.tx_uid));
        check_field("delay_first", 64'(m_axis_tdata[48]), 64'(want.delay_first));
        check_field("done_res", 64'(m_axis_tdata[49]), 64'(want.done_res));
        check_field("status", 64'(m_axis_tdata[51:50]), 64'(want.status));
        check_field("atqa_value", 64'(m_axis_tdata[67:52]), 64'(want.atqa_value));
        check_field("sak_value", 64'(m_axis_tdata[75:68]), 64'(want.sak_value));
        check_field("uid_chunk", 64'(m_axis_tdata[107:76]), 64'(want.uid_chunk));
        check_field("chunk_len", 64'(m_axis_tdata[110:108]), 64'(want.chunk_len));
        check_field("uid_total", 64'(m_axis_tdata[114:111]), 64'(want.uid_total));
      end
    end
  end

  // Watchdog: stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run hung after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    foreach (finish_hits[i]) finish_hits[i] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_retry_limits();
    test_random_traffic();
    test_backpressure();

    if (due_frames.size() != 0)
      report_mismatch($sformatf("%0d owed results never came", due_frames.size()));

    $display("covered %0d transactions in, %0d results out, retry limits 0, 1, 3, 7 and one more",
             total_items, frames_seen);
    $display("finished selections: ok %0d, no card %0d, collision %0d, protocol %0d",
             finish_hits[ST_OK], finish_hits[ST_NO_CARD], finish_hits[ST_COLLISION],
             finish_hits[ST_PROTOCOL]);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
